@@ rtl/core/bms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_pkg
// Shared constants, types and helper functions for the bullet motion step.
// ----------------------------------------------------------------------------
package bms_pkg;

    // Number of CORDIC iterations; the arctangent table holds up to 24.
    localparam int TRIG_STEPS = 16;
    localparam int TABLE_LEN  = 24;
    localparam int STEPS      = (TRIG_STEPS < TABLE_LEN) ? TRIG_STEPS : TABLE_LEN;

    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MIN_X   = 3'd0;
    localparam logic [2:0] CFG_MIN_Y   = 3'd1;
    localparam logic [2:0] CFG_MAX_X   = 3'd2;
    localparam logic [2:0] CFG_MAX_Y   = 3'd3;
    localparam logic [2:0] CFG_MARGIN  = 3'd4;
    localparam logic [2:0] CFG_MAR_EN  = 3'd5;

    // One item as it travels down the pipeline; results are filled in on the way.
    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic        [15:0] head;
        logic signed [23:0] spd;
        logic signed [23:0] ex;
        logic signed [23:0] ey;
        logic        [15:0] dt;
        logic        [22:0] margin;
        logic               spin;
        logic               face;
        logic        [1:0]  quad;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] nx;
        logic signed [23:0] ny;
        logic               outside;
    } t_item;

    // Arctangent of 2^-i in 32-bit binary turns.
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Saturate a 27-bit signed value to 24 bits.
    function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
        logic signed [23:0] r;
        if (v > 27'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -27'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/bullet_motion_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bullet_motion_step
// Fixed-point Euler step of one bullet record per transfer.
// ----------------------------------------------------------------------------
// Usage:
// Input records arrive on the in channel (i_in_valid / o_in_ready) and one
// result per record leaves on the out channel (o_out_valid / i_out_ready),
// in the same order. World bounds and margins are to be written through the
// plain configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) only while no
// record is in flight; the block itself does not enforce this.
// A record passes 2 * STEPS + 6 register stages: one input stage, one stage
// per sine/cosine iteration, two multiply and two add stages, one stage per
// arctangent iteration and the output register.
// Throughput is one record per cycle while the receiver does not stall; every stage is a full register stage.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready drops in the same cycle, so nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and loads the default
// world bounds; payload registers are not reset.
// ----------------------------------------------------------------------------
module bullet_motion_step
    import bms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic [15:0]        i_heading,
    input  logic signed [23:0] i_scalar_speed,
    input  logic signed [23:0] i_extra_vx,
    input  logic signed [23:0] i_extra_vy,
    input  logic [15:0]        i_frame_dt,
    input  logic [22:0]        i_own_margin,
    input  logic               i_spin_enable,
    input  logic               i_face_motion,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_next_x,
    output logic signed [23:0] o_next_y,
    output logic signed [23:0] o_vel_x,
    output logic signed [23:0] o_vel_y,
    output logic [15:0]        o_sprite_rotation,
    output logic               o_outside
);

    // Configuration registers.
    logic signed [23:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic [22:0]        r_margin;
    logic               r_mar_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x  <= -24'sd2560000;
            r_min_y  <= -24'sd2560000;
            r_max_x  <= 24'sd2560000;
            r_max_y  <= 24'sd2560000;
            r_margin <= '0;
            r_mar_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_X:  r_min_x  <= i_cfg_data;
                CFG_MIN_Y:  r_min_y  <= i_cfg_data;
                CFG_MAX_X:  r_max_x  <= i_cfg_data;
                CFG_MAX_Y:  r_max_y  <= i_cfg_data;
                CFG_MARGIN: r_margin <= i_cfg_data[22:0];
                CFG_MAR_EN: r_mar_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a result is waiting on a stalled receiver.
    logic r_out_v;
    logic adv;
    assign adv        = !r_out_v || i_out_ready;
    assign o_in_ready = adv;

    // Sine/cosine rotation stages; index 0 is the input register.
    logic signed [33:0] r_rx [0:STEPS];
    logic signed [33:0] r_ry [0:STEPS];
    logic signed [32:0] r_rz [0:STEPS];
    t_item              r_ri [0:STEPS];
    logic               r_rv [0:STEPS];

    // Input stage: capture the record, reduce the angle to the nearest quarter turn.
    logic [31:0] turn;
    logic [1:0]  quad;
    logic [31:0] resid;
    t_item       in_item;
    always_comb begin
        turn  = {i_heading, 16'd0};
        quad  = 2'((turn + 32'h2000_0000) >> 30);
        resid = turn - {quad, 30'd0};
        in_item         = '0;
        in_item.px      = i_pos_x;
        in_item.py      = i_pos_y;
        in_item.head    = i_heading;
        in_item.spd     = i_scalar_speed;
        in_item.ex      = i_extra_vx;
        in_item.ey      = i_extra_vy;
        in_item.dt      = i_frame_dt;
        in_item.margin  = r_mar_en ? r_margin : i_own_margin;
        in_item.spin    = i_spin_enable;
        in_item.face    = i_face_motion;
        in_item.quad    = quad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv[0] <= 1'b0;
        end else if (adv) begin
            r_rv[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rx[0] <= 34'(CORDIC_GAIN);
            r_ry[0] <= '0;
            r_rz[0] <= {resid[31], resid};
            r_ri[0] <= in_item;
        end
    end

    // One rotation iteration per stage.
    for (genvar k = 0; k < STEPS; k++) begin : g_rot
        logic signed [33:0] dx, dy;
        assign dx = r_ry[k] >>> k;
        assign dy = r_rx[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[k+1] <= 1'b0;
            end else if (adv) begin
                r_rv[k+1] <= r_rv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ri[k+1] <= r_ri[k];
                if (!r_rz[k][32]) begin
                    r_rx[k+1] <= r_rx[k] - dx;
                    r_ry[k+1] <= r_ry[k] + dy;
                    r_rz[k+1] <= r_rz[k] - $signed({1'b0, atan_turn(k)});
                end else begin
                    r_rx[k+1] <= r_rx[k] + dx;
                    r_ry[k+1] <= r_ry[k] - dy;
                    r_rz[k+1] <= r_rz[k] + $signed({1'b0, atan_turn(k)});
                end
            end
        end
    end

    // Multiply stage: undo the quadrant reduction, scale by the speed.
    logic signed [31:0] cos_v, sin_v;
    always_comb begin
        case (r_ri[STEPS].quad)
            2'd0: begin
                cos_v = r_rx[STEPS][31:0];
                sin_v = r_ry[STEPS][31:0];
            end
            2'd1: begin
                cos_v = 32'(-r_ry[STEPS]);
                sin_v = r_rx[STEPS][31:0];
            end
            2'd2: begin
                cos_v = 32'(-r_rx[STEPS]);
                sin_v = 32'(-r_ry[STEPS]);
            end
            default: begin
                cos_v = r_ry[STEPS][31:0];
                sin_v = 32'(-r_rx[STEPS]);
            end
        endcase
    end

    logic signed [55:0] r_pcx, r_pcy;
    t_item              r_mi;
    logic               r_mv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (adv) begin
            r_mv <= r_rv[STEPS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pcx <= cos_v * r_ri[STEPS].spd;
            r_pcy <= sin_v * r_ri[STEPS].spd;
            r_mi  <= r_ri[STEPS];
        end
    end

    // Velocity stage: round, add the extra speed and saturate.
    logic signed [55:0] rnd_x, rnd_y;
    logic signed [26:0] sum_vx, sum_vy;
    t_item              vel_item;
    always_comb begin
        rnd_x  = r_pcx + 56'sd536870912;
        rnd_y  = r_pcy + 56'sd536870912;
        sum_vx = {rnd_x[55], rnd_x[55:30]} + 27'(r_mi.ex);
        sum_vy = {rnd_y[55], rnd_y[55:30]} + 27'(r_mi.ey);
        vel_item    = r_mi;
        vel_item.vx = sat24(sum_vx);
        vel_item.vy = sat24(sum_vy);
    end

    t_item r_vi;
    logic  r_vv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv <= 1'b0;
        end else if (adv) begin
            r_vv <= r_mv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_vi <= vel_item;
        end
    end

    // Step multiply: velocity times the frame delta.
    logic signed [40:0] r_pdx, r_pdy;
    t_item              r_di;
    logic               r_dv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (adv) begin
            r_dv <= r_vv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pdx <= r_vi.vx * $signed({1'b0, r_vi.dt});
            r_pdy <= r_vi.vy * $signed({1'b0, r_vi.dt});
            r_di  <= r_vi;
        end
    end

    // Position stage: round, add, saturate and check against the widened bounds.
    logic signed [40:0] rnd_dx, rnd_dy;
    logic signed [26:0] sum_nx, sum_ny;
    logic signed [26:0] lo_x, lo_y, hi_x, hi_y, mar;
    t_item              pos_item;
    always_comb begin
        rnd_dx = r_pdx + 41'sd32768;
        rnd_dy = r_pdy + 41'sd32768;
        sum_nx = 27'($signed(rnd_dx[40:16])) + 27'(r_di.px);
        sum_ny = 27'($signed(rnd_dy[40:16])) + 27'(r_di.py);
        mar    = $signed({4'd0, r_di.margin});
        lo_x   = 27'(r_min_x) - mar;
        lo_y   = 27'(r_min_y) - mar;
        hi_x   = 27'(r_max_x) + mar;
        hi_y   = 27'(r_max_y) + mar;
        pos_item    = r_di;
        pos_item.nx = sat24(sum_nx);
        pos_item.ny = sat24(sum_ny);
        pos_item.outside = (27'(pos_item.nx) < lo_x) || (27'(pos_item.ny) < lo_y) ||
                           (27'(pos_item.nx) > hi_x) || (27'(pos_item.ny) > hi_y);
    end

    // Arctangent vectoring stages; index 0 holds the half-plane folded start.
    logic signed [34:0] r_ax [0:STEPS];
    logic signed [34:0] r_ay [0:STEPS];
    logic [31:0]        r_az [0:STEPS];
    t_item              r_ai [0:STEPS];
    logic               r_av [0:STEPS];

    logic signed [34:0] sx, sy;
    assign sx = {{3{pos_item.vx[23]}}, pos_item.vx, 8'd0};
    assign sy = {{3{pos_item.vy[23]}}, pos_item.vy, 8'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av[0] <= 1'b0;
        end else if (adv) begin
            r_av[0] <= r_dv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ai[0] <= pos_item;
            if (sx < 0) begin
                r_ax[0] <= -sx;
                r_ay[0] <= -sy;
                r_az[0] <= 32'h8000_0000;
            end else begin
                r_ax[0] <= sx;
                r_ay[0] <= sy;
                r_az[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_vec
        logic signed [34:0] dx, dy;
        assign dx = r_ay[k] >>> k;
        assign dy = r_ax[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av[k+1] <= 1'b0;
            end else if (adv) begin
                r_av[k+1] <= r_av[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ai[k+1] <= r_ai[k];
                if (!r_ay[k][34]) begin
                    r_ax[k+1] <= r_ax[k] + dx;
                    r_ay[k+1] <= r_ay[k] - dy;
                    r_az[k+1] <= r_az[k] + atan_turn(k);
                end else begin
                    r_ax[k+1] <= r_ax[k] - dx;
                    r_ay[k+1] <= r_ay[k] + dy;
                    r_az[k+1] <= r_az[k] - atan_turn(k);
                end
            end
        end
    end

    // Output register: choose the sprite rotation.
    t_item       fin;
    logic [31:0] az_rnd;
    logic [15:0] rot;
    always_comb begin
        fin    = r_ai[STEPS];
        az_rnd = r_az[STEPS] + 32'h0000_8000;
        if (!fin.spin) begin
            rot = '0;
        end else if (fin.face && (fin.vx != 0 || fin.vy != 0)) begin
            rot = az_rnd[31:16];
        end else begin
            rot = fin.head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_av[STEPS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_next_x          <= fin.nx;
            o_next_y          <= fin.ny;
            o_vel_x           <= fin.vx;
            o_vel_y           <= fin.vy;
            o_sprite_rotation <= rot;
            o_outside         <= fin.outside;
        end
    end

    assign o_out_valid = r_out_v;

endmodule

@@ rtl/core/bms_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_checker
// Port-level checks on the bullet motion step, bound to the top level.
// ----------------------------------------------------------------------------
module bms_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic [23:0] o_next_x
);

    // The input side is held exactly while a result waits on a stalled receiver.
    a_ready_follows_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow the output stall");

    // A pending result is not dropped, and its x position does not change, while stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_next_x))
        else $error("stalled result changed or vanished");

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result offered straight after reset");

endmodule

bind bullet_motion_step bms_checker u_bms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_next_x    (o_next_x)
);
